// File: sv/rgl_pkg.sv
// Shared types and constants for the RSSI gate lap timer.
package rgl_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned RUN_W    = 16;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CFG_W    = 16;

  localparam logic [COUNT_W-1:0]  MAX_LAPS       = 7'd64;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_INIT = 10'd512;
  localparam logic [RUN_W-1:0]    DEBOUNCE_INIT  = 16'd5000;

  // register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DEBOUNCE  = 1'b1;

  typedef struct packed {
    logic               above_mark;
    logic               race_finished;
    logic               lap_overflow;
    logic [COUNT_W-1:0] lap_count;
    logic [TICK_W-1:0]  lap_duration;
    logic               lap_flag;
    logic               lap_event;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int unsigned IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;

endpackage

// File: sv/rgl_core.sv
// Lap detection state and per-sample result computation.
module rgl_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rgl_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        accept,
  input  logic [rgl_pkg::SAMPLE_W-1:0] sample,
  output rgl_pkg::result_t            result
);

  logic [rgl_pkg::SAMPLE_W-1:0] threshold;
  logic [rgl_pkg::RUN_W-1:0]    debounce;
  logic [rgl_pkg::TICK_W-1:0]   tick_count, last_lap_tick, last_duration;
  logic [rgl_pkg::COUNT_W-1:0]  laps_seen;
  logic [rgl_pkg::RUN_W-1:0]    high_run, low_run;
  logic above_state, lap_level, finished_state, overflow_state;

  logic [rgl_pkg::TICK_W-1:0]   tick_count_next, last_lap_tick_next, last_duration_next;
  logic [rgl_pkg::COUNT_W-1:0]  laps_seen_next;
  logic [rgl_pkg::RUN_W-1:0]    high_run_next, low_run_next;
  logic above_state_next, lap_level_next, finished_state_next, overflow_state_next;
  logic lap_hit;

  always_comb begin
    tick_count_next     = tick_count + 1'b1;
    last_lap_tick_next  = last_lap_tick;
    last_duration_next  = last_duration;
    laps_seen_next      = laps_seen;
    high_run_next       = high_run;
    low_run_next        = low_run;
    above_state_next    = above_state;
    lap_level_next      = lap_level;
    finished_state_next = finished_state;
    overflow_state_next = overflow_state;
    lap_hit             = 1'b0;
    if (sample >= threshold) begin
      if (!above_state && low_run >= debounce) begin
        lap_hit            = 1'b1;
        above_state_next   = 1'b1;
        last_duration_next = tick_count_next - last_lap_tick;
        if (laps_seen < rgl_pkg::MAX_LAPS) begin
          laps_seen_next = laps_seen + 1'b1;
        end else begin
          overflow_state_next = 1'b1;
        end
        lap_level_next     = 1'b1;
        last_lap_tick_next = tick_count_next;
        high_run_next      = '0;
        low_run_next       = '0;
      end else if (above_state && high_run >= debounce) begin
        above_state_next    = 1'b0;
        finished_state_next = 1'b1;
      end else if (high_run < debounce) begin
        high_run_next = high_run + 1'b1;
      end
    end else begin
      lap_level_next   = 1'b0;
      above_state_next = 1'b0;
      high_run_next    = '0;
      if (low_run < debounce) begin
        low_run_next = low_run + 1'b1;
      end
    end
  end

  always_comb begin
    result.lap_event     = lap_hit;
    result.lap_flag      = lap_level_next;
    result.lap_duration  = last_duration_next;
    result.lap_count     = laps_seen_next;
    result.lap_overflow  = overflow_state_next;
    result.race_finished = finished_state_next;
    result.above_mark    = above_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rgl_pkg::THRESHOLD_INIT;
      debounce  <= rgl_pkg::DEBOUNCE_INIT;
    end else if (cfg_we) begin
      case (cfg_index)
        rgl_pkg::REG_THRESHOLD: threshold <= cfg_data[rgl_pkg::SAMPLE_W-1:0];
        rgl_pkg::REG_DEBOUNCE:  debounce  <= cfg_data[rgl_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      last_lap_tick  <= '0;
      last_duration  <= '0;
      laps_seen      <= '0;
      high_run       <= '0;
      low_run        <= '0;
      above_state    <= 1'b0;
      lap_level      <= 1'b0;
      finished_state <= 1'b0;
      overflow_state <= 1'b0;
    end else if (accept) begin
      tick_count     <= tick_count_next;
      last_lap_tick  <= last_lap_tick_next;
      last_duration  <= last_duration_next;
      laps_seen      <= laps_seen_next;
      high_run       <= high_run_next;
      low_run        <= low_run_next;
      above_state    <= above_state_next;
      lap_level      <= lap_level_next;
      finished_state <= finished_state_next;
      overflow_state <= overflow_state_next;
    end
  end

endmodule

// File: sv/rgl_out_buf.sv
// Two-entry result buffer between the core and the master stream.
module rgl_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rgl_pkg::result_t din,
  output logic             ready,
  output logic             valid,
  input  logic             pop,
  output rgl_pkg::result_t dout
);

  rgl_pkg::result_t slot0, slot1;
  logic [1:0] fill;

  assign ready = (fill != 2'd2);
  assign valid = (fill != 2'd0);
  assign dout  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (fill == 2'd0) begin
          slot0 <= din;
        end else begin
          slot1 <= din;
        end
      end
      2'b01: slot0 <= slot1;
      2'b11: begin
        if (fill == 2'd1) begin
          slot0 <= din;
        end else begin
          slot0 <= slot1;
          slot1 <= din;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/rssi_gate_lap_timer_unit.sv
// Top level of the RSSI gate lap timer.
// Each request on the slave stream is one RSSI sample (one tick) and gives exactly one
// result on the master stream, in the cycle after the sample is taken at the earliest.
// A sample can be taken every cycle: the lap state is computed by combinational counter
// and compare logic, and a two-entry result buffer lets the next sample in while a result
// waits. The input stalls only when both buffer entries are held. Configuration writes
// are taken at any time but should be made only while the block is idle.
module rssi_gate_lap_timer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [rgl_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rgl_pkg::IN_DATA_W-1:0]  s_tdata,   // [9:0] rssi_sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] lap_event, [1] lap_flag, [33:2] lap_duration, [40:34] lap_count,
  // [41] lap_overflow, [42] race_finished, [43] above_mark
  output logic [rgl_pkg::OUT_DATA_W-1:0] m_tdata
);

  rgl_pkg::result_t core_res, buf_res;
  logic accept;

  assign accept = s_tvalid && s_tready;

  rgl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample    (s_tdata[rgl_pkg::SAMPLE_W-1:0]),
    .result    (core_res)
  );

  rgl_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (core_res),
    .ready (s_tready),
    .valid (m_tvalid),
    .pop   (m_tvalid && m_tready),
    .dout  (buf_res)
  );

  assign m_tdata = {{(rgl_pkg::OUT_DATA_W - rgl_pkg::RESULT_W){1'b0}}, buf_res};

  a_lap_marks: assert property (@(posedge clk) disable iff (rst)
    accept && core_res.lap_event |-> core_res.lap_flag && core_res.above_mark)
    else $error("lap without flag and mark");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    accept |-> core_res.lap_count <= rgl_pkg::MAX_LAPS)
    else $error("lap count above limit");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && core_res.lap_overflow ##1 accept |-> core_res.lap_overflow)
    else $error("overflow flag cleared");

  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && core_res.race_finished ##1 accept |-> core_res.race_finished)
    else $error("finish flag cleared");

endmodule

// File: tb/testbench.sv
// Testbench for the RSSI gate lap timer: directed and random samples, scored per tick.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  class lap_timer_model;
    logic [rgl_pkg::SAMPLE_W-1:0] threshold;
    logic [rgl_pkg::RUN_W-1:0]    debounce;
    logic [rgl_pkg::TICK_W-1:0]   ticks;
    logic [rgl_pkg::TICK_W-1:0]   last_lap_at;
    logic [rgl_pkg::TICK_W-1:0]   duration;
    logic [rgl_pkg::COUNT_W-1:0]  laps;
    logic [rgl_pkg::RUN_W-1:0]    high_run;
    logic [rgl_pkg::RUN_W-1:0]    low_run;
    logic                         above;
    logic                         flag;
    logic                         finished;
    logic                         overflow;
    rgl_pkg::result_t             pending_results[$];
    int                           errors;
    int                           samples_seen;
    int                           laps_total;
    int                           finishes;

    function new();
      threshold    = rgl_pkg::THRESHOLD_INIT;
      debounce     = rgl_pkg::DEBOUNCE_INIT;
      ticks        = '0;
      last_lap_at  = '0;
      duration     = '0;
      laps         = '0;
      high_run     = '0;
      low_run      = '0;
      above        = 1'b0;
      flag         = 1'b0;
      finished     = 1'b0;
      overflow     = 1'b0;
      errors       = 0;
      samples_seen = 0;
      laps_total   = 0;
      finishes     = 0;
    endfunction

    function void set_register(logic idx, logic [rgl_pkg::CFG_W-1:0] value);
      case (idx)
        rgl_pkg::REG_THRESHOLD: threshold = value[rgl_pkg::SAMPLE_W-1:0];
        rgl_pkg::REG_DEBOUNCE: debounce = value[rgl_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [rgl_pkg::RUN_W-1:0] run_step(logic [rgl_pkg::RUN_W-1:0] run);
      return (run < debounce) ? run + 1'b1 : run;
    endfunction

    function void note_sample(logic [rgl_pkg::SAMPLE_W-1:0] sample);
      rgl_pkg::result_t res;
      logic             lap;
      lap = 1'b0;
      ticks++;
      samples_seen++;
      if (sample >= threshold) begin
        if (!above && low_run >= debounce) begin
          above    = 1'b1;
          duration = ticks - last_lap_at;
          if (laps < rgl_pkg::MAX_LAPS) begin
            laps++;
          end else begin
            overflow = 1'b1;
          end
          flag        = 1'b1;
          lap         = 1'b1;
          last_lap_at = ticks;
          high_run    = '0;
          low_run     = '0;
          laps_total++;
        end else if (above && high_run >= debounce) begin
          above    = 1'b0;
          finished = 1'b1;
          finishes++;
        end else begin
          high_run = run_step(high_run);
        end
      end else begin
        flag     = 1'b0;
        above    = 1'b0;
        high_run = '0;
        low_run  = run_step(low_run);
      end
      res.lap_event     = lap;
      res.lap_flag      = flag;
      res.lap_duration  = duration;
      res.lap_count     = laps;
      res.lap_overflow  = overflow;
      res.race_finished = finished;
      res.above_mark    = above;
      pending_results = {pending_results, res};
    endfunction

    function void compare(string field, logic [rgl_pkg::TICK_W-1:0] want,
                          logic [rgl_pkg::TICK_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [rgl_pkg::OUT_DATA_W-1:0] data);
      rgl_pkg::result_t want;
      rgl_pkg::result_t got;
      got = rgl_pkg::result_t'(data[rgl_pkg::RESULT_W-1:0]);
      if (pending_results.size() == 0) begin
        $error("result with no sample outstanding: %h", data);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare("lap_event", want.lap_event, got.lap_event);
      compare("lap_flag", want.lap_flag, got.lap_flag);
      compare("lap_duration", want.lap_duration, got.lap_duration);
      compare("lap_count", want.lap_count, got.lap_count);
      compare("lap_overflow", want.lap_overflow, got.lap_overflow);
      compare("race_finished", want.race_finished, got.race_finished);
      compare("above_mark", want.above_mark, got.above_mark);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic                           cfg_index = rgl_pkg::REG_THRESHOLD;
  logic [rgl_pkg::CFG_W-1:0]      cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [rgl_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [rgl_pkg::OUT_DATA_W-1:0] m_tdata;

  lap_timer_model model = new();
  int send_idle = 24;
  int recv_idle = 65;
  int hold_left = 0;
  int cycle_count = 0;
  int settings_used = 0;

  rssi_gate_lap_timer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        model.note_sample(s_tdata[rgl_pkg::SAMPLE_W-1:0]);
      end
      if (m_tvalid && m_tready) begin
        model.check_result(m_tdata);
      end
    end
  end

  // receiver: random back-pressure, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               model.pending_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic drive_sample(input logic [rgl_pkg::SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rgl_pkg::IN_DATA_W'(sample);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (model.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [rgl_pkg::CFG_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    model.set_register(idx, value);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [rgl_pkg::SAMPLE_W-1:0] thr,
                           input logic [rgl_pkg::RUN_W-1:0] deb);
    write_reg(rgl_pkg::REG_THRESHOLD, rgl_pkg::CFG_W'(thr));
    write_reg(rgl_pkg::REG_DEBOUNCE, rgl_pkg::CFG_W'(deb));
    settings_used++;
  endtask

  task automatic feed_samples(input logic [rgl_pkg::SAMPLE_W-1:0] seq[$]);
    foreach (seq[i]) drive_sample(seq[i]);
  endtask

  function automatic logic [rgl_pkg::SAMPLE_W-1:0] below_level();
    return rgl_pkg::SAMPLE_W'($urandom_range(int'(model.threshold) - 1, 0));
  endfunction

  function automatic logic [rgl_pkg::SAMPLE_W-1:0] above_level();
    return rgl_pkg::SAMPLE_W'($urandom_range(1023, int'(model.threshold)));
  endfunction

  // mostly clean laps (quiet run then a pass), some short quiet runs, some noise
  task automatic run_random(input int n);
    int sent;
    int kind;
    int len;
    int deb;
    sent = 0;
    deb  = int'(model.debounce);
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        if (model.threshold != 0) begin
          len = (kind < 5) ? deb + $urandom_range(3) : $urandom_range(deb, 0);
          repeat (len) begin
            drive_sample(below_level());
            sent++;
          end
        end
        len = $urandom_range(2 * deb + 2, 1);
        repeat (len) begin
          drive_sample(above_level());
          sent++;
        end
      end else begin
        len = $urandom_range(5, 1);
        repeat (len) begin
          drive_sample(rgl_pkg::SAMPLE_W'($urandom_range(1023, 0)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [rgl_pkg::SAMPLE_W-1:0] quiet[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: laps, finish, flag drop, zero debounce, threshold extremes
    configure(10'd512, 16'd2);
    feed_samples('{10'd1023, 10'd0, 10'd511, 10'd0, 10'd512, 10'd1023, 10'd1023,
                   10'd1023, 10'd1023, 10'd0, 10'd0, 10'd768});
    write_reg(rgl_pkg::REG_DEBOUNCE, 16'd0);
    feed_samples('{10'd600, 10'd600, 10'd600, 10'd100});
    configure(10'd0, 16'd0);
    feed_samples('{10'd0, 10'd0});
    configure(10'd1023, 16'd1);
    feed_samples('{10'd1022, 10'd1023, 10'd1022, 10'd1023});
    // quiet run left short of debounce, then debounce lowered under it
    configure(10'd512, 16'd12);
    quiet = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
    feed_samples(quiet);
    write_reg(rgl_pkg::REG_DEBOUNCE, 16'd3);
    feed_samples('{10'd700});
    write_reg(rgl_pkg::REG_DEBOUNCE, 16'd65535);
    feed_samples('{10'd0, 10'd0, 10'd900, 10'd1});

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 24;
          recv_idle = 65;
        end
        1: begin
          send_idle = 65;
          recv_idle = 24;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (phase == 2) begin
        // receiver holds off while requests keep coming, so the input stalls
        drain();
        hold_left = 150;
        repeat (40) drive_sample(rgl_pkg::SAMPLE_W'($urandom_range(1023, 0)));
      end
      for (int k = 0; k < 3; k++) begin
        case (k)
          0: configure(rgl_pkg::SAMPLE_W'($urandom_range(1023, 1)),
                       rgl_pkg::RUN_W'($urandom_range(4, 1)));
          1: begin
            case (phase)
              0: configure(10'd1023, 16'd3);
              1: configure(10'd1, 16'd6);
              default: configure(10'd0, 16'd0);
            endcase
          end
          default: configure(rgl_pkg::SAMPLE_W'($urandom_range(1023, 1)),
                             rgl_pkg::RUN_W'($urandom_range(2, 0)));
        endcase
        run_random(220);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("%0d samples over %0d threshold/debounce settings", model.samples_seen,
             settings_used);
    $display("%0d laps, %0d race finishes, lap count %0d, overflow %0b", model.laps_total,
             model.finishes, model.laps, model.overflow);
    if (model.errors == 0 && model.pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/rgl_pkg.sv
sv/rgl_core.sv
sv/rgl_out_buf.sv
sv/rssi_gate_lap_timer_unit.sv
tb/testbench.sv
